// ===== rtl/lsbc_pkg.sv =====
// Package for the link supervisor: timer widths, register indexes and the state type.
package lsbc_pkg;

    // Width of the elapsed-tick timers, less the saturation headroom bit.
    localparam int TIMER_BITS = 16;
    localparam int ELAPSED_W  = TIMER_BITS + 1;

    // Configuration registers are all 16 bits wide.
    localparam int REG_W   = 16;
    localparam int INDEX_W = 2;

    // Comparisons are made at the wider of the timer and register widths.
    localparam int CMP_W = (ELAPSED_W > REG_W) ? ELAPSED_W : REG_W;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = {ELAPSED_W{1'b1}};
    localparam logic [ELAPSED_W-1:0] ELAPSED_START =
        {1'b1, {TIMER_BITS{1'b0}}};

    // Register indexes on the configuration port.
    localparam logic [INDEX_W-1:0] REG_RECONNECT_HOLDOFF  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_BLINK_SHORT_PERIOD = 2'd1;
    localparam logic [INDEX_W-1:0] REG_BLINK_LONG_PERIOD  = 2'd2;

    // Register reset values.
    localparam logic [REG_W-1:0] RESET_RECONNECT_HOLDOFF  = 16'd5000;
    localparam logic [REG_W-1:0] RESET_BLINK_SHORT_PERIOD = 16'd200;
    localparam logic [REG_W-1:0] RESET_BLINK_LONG_PERIOD  = 16'd1000;

    // Link status codes as sampled.
    localparam logic [1:0] STATUS_DOWN      = 2'd0;
    localparam logic [1:0] STATUS_CONNECTED = 2'd2;

    // Supervisor states.
    typedef enum logic [1:0] {
        ST_DISCONNECTED = 2'd0,
        ST_CONNECTING   = 2'd1,
        ST_SUBSCRIBING  = 2'd2,
        ST_ONLINE       = 2'd3
    } t_link_state;

    // Saturating increment of an elapsed-tick timer.
    function automatic logic [ELAPSED_W-1:0] tick_up(input logic [ELAPSED_W-1:0] v);
        tick_up = (v == ELAPSED_MAX) ? v : v + ELAPSED_W'(1);
    endfunction

    // Strict compare of a timer against a register value.
    function automatic logic exceeds(input logic [ELAPSED_W-1:0] v,
                                     input logic [REG_W-1:0] period);
        exceeds = CMP_W'(v) > CMP_W'(period);
    endfunction

endpackage

// ===== rtl/link_supervisor_blink_code.sv =====
// Top level of the link supervisor with its blink-code status LED.

// Each accepted input transfer is one millisecond tick carrying the sampled
// link status. The block steps a four-state supervisor (disconnected,
// connecting, subscribing, online), raises one-tick connect and subscribe
// requests, and drives the LED with a blink code of the state before the
// tick. The state registers are updated and the result is loaded into
// the output register on the edge that accepts the tick, so a new tick
// can be accepted in every cycle while the downstream side keeps taking
// results. The output register is the only buffer, so the input is
// stalled only while a result waits and is not being taken. Configuration
// writes take effect at the next edge.
module link_supervisor_blink_code (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port
    input  logic                       i_cfg_we,
    input  logic [lsbc_pkg::INDEX_W-1:0] i_cfg_index,
    input  logic [lsbc_pkg::REG_W-1:0]   i_cfg_data,
    // Input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_link_status,
    // Output channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_led_on,
    output logic                       o_connect_request,
    output logic                       o_subscribe_request,
    output logic [1:0]                 o_supervisor_state
);
    import lsbc_pkg::*;

    // Configuration registers
    logic [REG_W-1:0] r_reconnect_holdoff;
    logic [REG_W-1:0] r_blink_short_period;
    logic [REG_W-1:0] r_blink_long_period;

    // Supervisor and LED state
    t_link_state          r_state, n_state;
    logic [ELAPSED_W-1:0] r_reconnect_elapsed, n_reconnect_elapsed;
    logic [ELAPSED_W-1:0] r_blink_elapsed, n_blink_elapsed;
    logic [2:0]           r_blink_count, n_blink_count;
    logic                 r_blink_phase, n_blink_phase;
    logic                 r_led_level, n_led_level;

    // Output register
    logic       r_out_valid;
    logic       r_led_on;
    logic       r_connect_request, n_connect_request;
    logic       r_subscribe_request, n_subscribe_request;
    logic [1:0] r_supervisor_state;

    logic       in_xfer;
    logic [ELAPSED_W-1:0] reconnect_tick;
    logic [ELAPSED_W-1:0] blink_tick;
    logic [2:0] burst_len;

    // A tick is taken whenever the output register is free or being emptied.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reconnect_holdoff  <= RESET_RECONNECT_HOLDOFF;
            r_blink_short_period <= RESET_BLINK_SHORT_PERIOD;
            r_blink_long_period  <= RESET_BLINK_LONG_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RECONNECT_HOLDOFF:  r_reconnect_holdoff  <= i_cfg_data;
                REG_BLINK_SHORT_PERIOD: r_blink_short_period <= i_cfg_data;
                REG_BLINK_LONG_PERIOD:  r_blink_long_period  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state of the supervisor, the blink sequencer and the requests.
    always_comb begin
        reconnect_tick = tick_up(r_reconnect_elapsed);
        blink_tick     = tick_up(r_blink_elapsed);
        burst_len      = {1'b0, r_state} + 3'd1;

        n_blink_elapsed = blink_tick;
        n_blink_count   = r_blink_count;
        n_blink_phase   = r_blink_phase;
        n_led_level     = r_led_level;

        // LED: dark gap once the burst is over, else toggle on the short period.
        if (r_blink_count > burst_len) begin
            n_led_level = 1'b0;
            if (exceeds(blink_tick, r_blink_long_period)) begin
                n_blink_elapsed = '0;
                n_blink_count   = '0;
            end
        end else if (exceeds(blink_tick, r_blink_short_period)) begin
            n_blink_elapsed = '0;
            n_led_level     = r_blink_phase;
            if (r_blink_phase) begin
                n_blink_count = r_blink_count + 3'd1;
            end
            n_blink_phase = !r_blink_phase;
        end

        n_state             = r_state;
        n_reconnect_elapsed = reconnect_tick;
        n_connect_request   = 1'b0;
        n_subscribe_request = 1'b0;

        // Supervisor; a status code of three counts as a connecting phase.
        case (r_state)
            ST_DISCONNECTED: begin
                if (exceeds(reconnect_tick, r_reconnect_holdoff)) begin
                    n_connect_request = 1'b1;
                    n_state           = ST_CONNECTING;
                end
            end
            ST_CONNECTING: begin
                if (i_link_status == STATUS_DOWN) begin
                    n_state             = ST_DISCONNECTED;
                    n_reconnect_elapsed = '0;
                end else if (i_link_status == STATUS_CONNECTED) begin
                    n_state = ST_SUBSCRIBING;
                end
            end
            ST_SUBSCRIBING: begin
                if (i_link_status != STATUS_CONNECTED) begin
                    n_state             = ST_DISCONNECTED;
                    n_reconnect_elapsed = '0;
                end else begin
                    n_subscribe_request = 1'b1;
                    n_state             = ST_ONLINE;
                end
            end
            default: begin
                if (i_link_status != STATUS_CONNECTED) begin
                    n_state             = ST_DISCONNECTED;
                    n_reconnect_elapsed = '0;
                end
            end
        endcase
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= ST_DISCONNECTED;
            r_reconnect_elapsed <= ELAPSED_START;
            r_blink_elapsed     <= '0;
            r_blink_count       <= '0;
            r_blink_phase       <= 1'b0;
            r_led_level         <= 1'b0;
        end else if (in_xfer) begin
            r_state             <= n_state;
            r_reconnect_elapsed <= n_reconnect_elapsed;
            r_blink_elapsed     <= n_blink_elapsed;
            r_blink_count       <= n_blink_count;
            r_blink_phase       <= n_blink_phase;
            r_led_level         <= n_led_level;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_led_on            <= n_led_level;
            r_connect_request   <= n_connect_request;
            r_subscribe_request <= n_subscribe_request;
            r_supervisor_state  <= n_state;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_led_on            = r_led_on;
    assign o_connect_request   = r_connect_request;
    assign o_subscribe_request = r_subscribe_request;
    assign o_supervisor_state  = r_supervisor_state;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the link supervisor, with a tick-by-tick predictor and checks.
module tb_top;
    import lsbc_pkg::*;

    // Status codes that the package leaves unnamed.
    localparam logic [1:0] STATUS_CONNECTING = 2'd1;
    localparam logic [1:0] STATUS_ODD        = 2'd3;

    // An index beyond the register list, to show that such writes are dropped.
    localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 305;

    // One expected result of a tick.
    typedef struct packed {
        logic        led;
        logic        conn;
        logic        sub;
        t_link_state state;
    } t_tick_result;

    // Predicts the supervisor tick by tick and holds the results still to come.
    class t_tick_scoreboard;
        logic [REG_W-1:0]     holdoff;
        logic [REG_W-1:0]     short_gap;
        logic [REG_W-1:0]     long_gap;
        t_link_state          sup_state;
        logic [ELAPSED_W-1:0] since_drop;
        logic [ELAPSED_W-1:0] since_blink;
        logic [2:0]           pulse_count;
        logic                 pulse_phase;
        logic                 led_level;
        t_tick_result         expected_q[$];
        int                   errors;

        function new();
            holdoff     = RESET_RECONNECT_HOLDOFF;
            short_gap   = RESET_BLINK_SHORT_PERIOD;
            long_gap    = RESET_BLINK_LONG_PERIOD;
            sup_state   = ST_DISCONNECTED;
            since_drop  = ELAPSED_START;
            since_blink = '0;
            pulse_count = '0;
            pulse_phase = 1'b0;
            led_level   = 1'b0;
            errors      = 0;
        endfunction

        function logic [ELAPSED_W-1:0] bump(input logic [ELAPSED_W-1:0] v);
            return (v == ELAPSED_MAX) ? v : v + 1'b1;
        endfunction

        function void write_reg(input logic [INDEX_W-1:0] idx, input logic [REG_W-1:0] v);
            case (idx)
                REG_RECONNECT_HOLDOFF:  holdoff   = v;
                REG_BLINK_SHORT_PERIOD: short_gap = v;
                REG_BLINK_LONG_PERIOD:  long_gap  = v;
                default: ;
            endcase
        endfunction

        // Step the predictor by one accepted tick and queue its result.
        function void note_tick(input logic [1:0] status);
            logic [2:0]   burst;
            t_tick_result res;
            res = '0;
            since_drop  = bump(since_drop);
            since_blink = bump(since_blink);

            // The blink code follows the state held before this tick.
            burst = {1'b0, sup_state} + 3'd1;
            if (pulse_count > burst) begin
                led_level = 1'b0;
                if (since_blink > long_gap) begin
                    since_blink = '0;
                    pulse_count = '0;
                end
            end else if (since_blink > short_gap) begin
                since_blink = '0;
                led_level   = pulse_phase;
                if (pulse_phase)
                    pulse_count = pulse_count + 3'd1;
                pulse_phase = ~pulse_phase;
            end

            // Supervisor transitions; any status other than down or connected
            // counts as still connecting.
            case (sup_state)
                ST_DISCONNECTED: begin
                    if (since_drop > holdoff) begin
                        res.conn  = 1'b1;
                        sup_state = ST_CONNECTING;
                    end
                end
                ST_CONNECTING: begin
                    if (status == STATUS_DOWN) begin
                        sup_state  = ST_DISCONNECTED;
                        since_drop = '0;
                    end else if (status == STATUS_CONNECTED) begin
                        sup_state = ST_SUBSCRIBING;
                    end
                end
                ST_SUBSCRIBING: begin
                    if (status != STATUS_CONNECTED) begin
                        sup_state  = ST_DISCONNECTED;
                        since_drop = '0;
                    end else begin
                        res.sub   = 1'b1;
                        sup_state = ST_ONLINE;
                    end
                end
                default: begin
                    if (status != STATUS_CONNECTED) begin
                        sup_state  = ST_DISCONNECTED;
                        since_drop = '0;
                    end
                end
            endcase

            res.led   = led_level;
            res.state = sup_state;
            expected_q.push_back(res);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string msg);
            $display("tb_top: mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest expectation.
        task check_result(input logic led, input logic conn, input logic sub,
                          input logic [1:0] state);
            t_tick_result exp_res;
            if (expected_q.size() == 0) begin
                report("result transfer with nothing expected");
                return;
            end
            exp_res = expected_q.pop_front();
            if (led !== exp_res.led)
                report($sformatf("led_on %b, expected %b", led, exp_res.led));
            if (conn !== exp_res.conn)
                report($sformatf("connect_request %b, expected %b", conn, exp_res.conn));
            if (sub !== exp_res.sub)
                report($sformatf("subscribe_request %b, expected %b", sub, exp_res.sub));
            if (state !== exp_res.state)
                report($sformatf("supervisor_state %0d, expected %0d", state, exp_res.state));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         link_status = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               led_on;
    logic               connect_request;
    logic               subscribe_request;
    logic [1:0]         supervisor_state;

    bit                 calm = 1'b0;
    int                 stall_cycles = 0;
    t_tick_scoreboard   sb = new();

    // Directed ticks at the reset settings: connect, odd status, subscribe, drop.
    logic [1:0] directed_a [10] = '{STATUS_DOWN, STATUS_ODD, STATUS_CONNECTING,
        STATUS_CONNECTED, STATUS_CONNECTED, STATUS_CONNECTED, STATUS_ODD,
        STATUS_DOWN, STATUS_CONNECTED, STATUS_DOWN};
    // Directed ticks at short settings: drops from connecting and subscribing, and fast bursts.
    logic [1:0] directed_b [16] = '{STATUS_CONNECTING, STATUS_CONNECTED,
        STATUS_DOWN, STATUS_DOWN, STATUS_DOWN, STATUS_DOWN, STATUS_DOWN,
        STATUS_CONNECTED, STATUS_CONNECTED, STATUS_CONNECTED, STATUS_CONNECTED,
        STATUS_CONNECTING, STATUS_DOWN, STATUS_DOWN, STATUS_DOWN, STATUS_ODD};

    link_supervisor_blink_code dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_link_status       (link_status),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_led_on            (led_on),
        .o_connect_request   (connect_request),
        .o_subscribe_request (subscribe_request),
        .o_supervisor_state  (supervisor_state)
    );

    always #2 i_clk = ~i_clk;

    // The receiver stalls now and then, except during calm stretches.
    always @(negedge i_clk) begin
        out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end

    // Result monitor and stall watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            sb.check_result(led_on, connect_request, subscribe_request, supervisor_state);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Offer one tick, with an occasional gap first; valid stays high afterwards.
    task automatic send_tick(input logic [1:0] status);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 10) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid    <= 1'b1;
        link_status <= status;
        do @(posedge i_clk); while (!in_ready);
        sb.note_tick(status);
    endtask

    // Stop sending and wait until every expected result has been taken.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [INDEX_W-1:0] idx, input logic [REG_W-1:0] v);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        sb.write_reg(idx, v);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [REG_W-1:0] holdoff, input logic [REG_W-1:0] short_gap,
                              input logic [REG_W-1:0] long_gap);
        drain();
        write_cfg(REG_RECONNECT_HOLDOFF, holdoff);
        write_cfg(REG_BLINK_SHORT_PERIOD, short_gap);
        write_cfg(REG_BLINK_LONG_PERIOD, long_gap);
    endtask

    // Random ticks in runs of one status, so that the supervisor gets online
    // and stays there, mixed with short noisy runs.
    task automatic run_random(input int count, input bit pause_midway);
        int   left;
        int   run_len;
        int   pick;
        logic [1:0] status;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0) begin
                status  = 2'($urandom_range(0, 3));
                run_len = $urandom_range(1, 3);
            end else begin
                if (pick < 50)
                    status = STATUS_CONNECTED;
                else if (pick < 70)
                    status = STATUS_CONNECTING;
                else if (pick < 85)
                    status = STATUS_DOWN;
                else
                    status = STATUS_ODD;
                run_len = $urandom_range(1, 25);
            end
            if (run_len > left)
                run_len = left;
            repeat (run_len) begin
                send_tick(status);
                left--;
                if (pause_midway && left == count / 2)
                    drain();
            end
        end
    endtask

    // Main sequence: reset, directed ticks, then random phases over several settings.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_a[k])
            send_tick(directed_a[k]);
        set_config(16'd2, 16'd0, 16'd3);
        foreach (directed_b[k])
            send_tick(directed_b[k]);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: set_config(16'd0, 16'd0, 16'd0);
                2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                4: set_config(16'd1, 16'd0, 16'hFFFF);
                default: set_config(16'($urandom_range(0, 40)), 16'($urandom_range(0, 8)),
                                    16'($urandom_range(0, 60)));
            endcase
            if (p == 5)
                write_cfg(REG_UNUSED, 16'($urandom_range(0, 65535)));
            calm = (p == 3);
            run_random(PHASE_ITEMS, p == 1);
            calm = 1'b0;
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lsbc_pkg.sv
rtl/link_supervisor_blink_code.sv
test/tb_top.sv
